/* hw/rtl/htd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and sizes of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

	// table sizes
	localparam int MAX_NODES   = 512;
	localparam int STACK_DEPTH = 256;

	localparam int SYM_W = 8;
	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int DEP_W = $clog2(STACK_DEPTH + 1);
	// leaf entries keep a symbol, pending internal entries keep a stack link
	localparam int PAY_W = (IDX_W > SYM_W) ? IDX_W : SYM_W;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_DECODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_EARLY = 2'd2,
		ST_LATE  = 2'd3
	} status_t;

	// node table write: leaf flag plus symbol or link
	typedef struct packed {
		logic             en;
		idx_t             addr;
		logic             leaf;
		logic [PAY_W-1:0] pay;
	} node_wr_t;

	// right-child table write
	typedef struct packed {
		logic en;
		idx_t addr;
		idx_t data;
	} right_wr_t;

	// table read request
	typedef struct packed {
		logic en;
		idx_t addr;
	} rd_req_t;

	// builder status towards the rest of the block
	typedef struct packed {
		status_t status;
		logic    done;
		logic    done_nxt;
	} bld_stat_t;

endpackage

/* hw/rtl/htd_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_table
// Node table and right-child table, one write and one registered read each.
// ----------------------------------------------------------------------------
module htd_table import htd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  node_wr_t         node_wr,
	input  right_wr_t        right_wr,
	input  rd_req_t          walk_rd,
	input  rd_req_t          link_rd,
	output logic             rd_leaf,
	output logic [PAY_W-1:0] rd_pay,
	output idx_t             rd_right
);

	logic [PAY_W:0] node_mem [MAX_NODES];
	idx_t           right_mem [MAX_NODES];
	logic [PAY_W:0] node_rd_q;
	idx_t           right_rd_q;
	idx_t           rd_addr;
	logic           node_rd_en;

	// walk and stack-link reads share the node table port
	assign rd_addr    = walk_rd.en ? walk_rd.addr : link_rd.addr;
	assign node_rd_en = walk_rd.en | link_rd.en;

	// node table
	always_ff @(posedge clk) begin
		if (node_wr.en) begin
			node_mem[node_wr.addr] <= {node_wr.leaf, node_wr.pay};
		end
		if (node_rd_en) begin
			node_rd_q <= node_mem[rd_addr];
		end
	end

	// right-child table
	always_ff @(posedge clk) begin
		if (right_wr.en) begin
			right_mem[right_wr.addr] <= right_wr.data;
		end
		if (walk_rd.en) begin
			right_rd_q <= right_mem[walk_rd.addr];
		end
	end

	assign rd_leaf  = node_rd_q[PAY_W];
	assign rd_pay   = node_rd_q[PAY_W-1:0];
	assign rd_right = right_rd_q;

	// loads and decodes never share a beat
	a_one_reader: assert property (@(posedge clk) disable iff (!arst_n)
		!(walk_rd.en && link_rd.en))
		else $error("walk read and stack link read in the same cycle");

endmodule

/* hw/rtl/htd_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_builder
// Preorder tree loader: node counter, pending stack kept as a linked list
// through the node table, with the top two entries held in registers.
// ----------------------------------------------------------------------------
module htd_builder import htd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             ld_en,
	input  logic             is_leaf,
	input  logic [SYM_W-1:0] sym,
	input  logic [PAY_W-1:0] link_pay,
	output node_wr_t         node_wr,
	output right_wr_t        right_wr,
	output rd_req_t          link_rd,
	output bld_stat_t        stat
);

	logic [CNT_W-1:0] cnt_q;
	logic [DEP_W-1:0] depth_q;
	logic             lpend_q;
	logic             done_q;
	logic             lnk_q;
	idx_t             top_q;
	idx_t             next_q;

	idx_t             n;
	idx_t             eff_next;
	idx_t             below;
	logic             first;
	logic [DEP_W-1:0] dep_after;
	status_t          status;
	logic             commit;
	logic             pop;
	logic             push;

	// second stack entry, possibly still arriving from the table
	assign eff_next = lnk_q ? link_pay[IDX_W-1:0] : next_q;

	assign n         = cnt_q[IDX_W-1:0];
	assign first     = (cnt_q == '0);
	assign dep_after = (!first && !lpend_q) ? depth_q - DEP_W'(1) : depth_q;

	// load checks in priority order
	always_comb begin
		if (done_q) begin
			status = ST_LATE;
		end else if (cnt_q >= CNT_W'(MAX_NODES)) begin
			status = ST_OVF;
		end else if (!first && depth_q == '0) begin
			status = ST_OVF;
		end else if (!is_leaf && dep_after >= DEP_W'(STACK_DEPTH)) begin
			status = ST_OVF;
		end else begin
			status = ST_OK;
		end
	end

	assign commit = ld_en && (status == ST_OK);
	assign pop    = commit && !first && !lpend_q;
	assign push   = commit && !is_leaf;
	assign below  = pop ? eff_next : top_q;

	// table writes: new node, and right link of the popped parent
	assign node_wr.en   = commit;
	assign node_wr.addr = n;
	assign node_wr.leaf = is_leaf;
	assign node_wr.pay  = is_leaf ? PAY_W'(sym) : PAY_W'(below);

	assign right_wr.en   = pop;
	assign right_wr.addr = top_q;
	assign right_wr.data = n;

	// fetch the entry under the new top after a bare pop
	assign link_rd.en   = pop && !push;
	assign link_rd.addr = eff_next;

	assign stat.status   = ld_en ? status : ST_OK;
	assign stat.done     = done_q;
	assign stat.done_nxt = clr ? 1'b0 : (done_q || (commit && is_leaf && dep_after == '0));

	// builder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			depth_q <= '0;
			lpend_q <= 1'b0;
			done_q  <= 1'b0;
			lnk_q   <= 1'b0;
			top_q   <= '0;
			next_q  <= '0;
		end else if (clr) begin
			cnt_q   <= '0;
			depth_q <= '0;
			lpend_q <= 1'b0;
			done_q  <= 1'b0;
			lnk_q   <= 1'b0;
			top_q   <= '0;
			next_q  <= '0;
		end else if (commit) begin
			cnt_q   <= cnt_q + CNT_W'(1);
			depth_q <= push ? dep_after + DEP_W'(1) : dep_after;
			lpend_q <= push;
			done_q  <= is_leaf && dep_after == '0;
			lnk_q   <= pop && !push;
			if (push) begin
				top_q  <= n;
				next_q <= below;
			end else if (pop) begin
				top_q  <= eff_next;
			end else begin
				next_q <= eff_next;
			end
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEP_W'(STACK_DEPTH))
		else $error("pending stack deeper than its size");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> depth_q == '0)
		else $error("tree complete with nodes still pending");

endmodule

/* hw/rtl/htd_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htd_walker
// Decode walk: holds the current node and its right link, picks the child
// for each code bit and, unless the root is a leaf, issues the table read of that child.
// ----------------------------------------------------------------------------
module htd_walker import htd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             dec_en,
	input  logic             code_bit,
	input  logic             done,
	input  node_wr_t         node_wr,
	input  right_wr_t        right_wr,
	input  logic             rd_leaf,
	input  idx_t             rd_right,
	output rd_req_t          walk_rd,
	output logic             root_hit,
	output logic [SYM_W-1:0] root_sym
);

	logic             root_leaf_q;
	logic [SYM_W-1:0] root_sym_q;
	idx_t             root_right_q;
	idx_t             cur_idx_q;
	idx_t             cur_right_q;
	idx_t             nxt_q;
	logic             walk_q;

	idx_t             eff_idx;
	idx_t             eff_right;
	idx_t             nxt;
	logic             step;

	// current node, settled from the last read if a walk is outstanding
	assign eff_idx   = walk_q ? (rd_leaf ? '0 : nxt_q) : cur_idx_q;
	assign eff_right = (eff_idx == '0) ? root_right_q : (walk_q ? rd_right : cur_right_q);

	// preorder places the left child straight after its parent
	assign nxt  = code_bit ? eff_right : eff_idx + IDX_W'(1);
	assign step = dec_en && done && !root_leaf_q;

	assign walk_rd.en   = step;
	assign walk_rd.addr = nxt;

	assign root_hit = dec_en && done && root_leaf_q;
	assign root_sym = root_sym_q;

	// copies of the root entry
	always_ff @(posedge clk) begin
		if (node_wr.en && node_wr.addr == '0) begin
			root_leaf_q <= node_wr.leaf;
			root_sym_q  <= node_wr.pay[SYM_W-1:0];
		end
		if (right_wr.en && right_wr.addr == '0) begin
			root_right_q <= right_wr.data;
		end
	end

	// walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_idx_q   <= '0;
			cur_right_q <= '0;
			nxt_q       <= '0;
			walk_q      <= 1'b0;
		end else if (clr || root_hit) begin
			cur_idx_q <= '0;
			walk_q    <= 1'b0;
		end else if (step) begin
			cur_idx_q   <= eff_idx;
			cur_right_q <= eff_right;
			nxt_q       <= nxt;
			walk_q      <= 1'b1;
		end
	end

	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		walk_rd.en |-> done && !clr)
		else $error("tree walk on an incomplete tree");

endmodule

/* hw/rtl/huffman_tree_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Bit-serial Huffman decoder: loads a preorder code tree into tables and
// walks it one code bit per beat.
//
//   channel  dir  beat fields
//   s_axis   in   tuser: opcode; tdata: node_is_leaf, leaf_symbol, code_bit
//   m_axis   out  tuser: symbol_valid; tdata: symbol, status, tree_complete
//
// One beat in and one beat out per cycle while m_axis does not stall; a result
// passes the table read stage, then the output register, before it leaves.
// A decode bit reads the chosen child from the node tables; the next bit
// picks its child from that read data.
// Reset clears control state only; table entries are undefined until loaded.
// A stall on m_axis fills the read stage and then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module huffman_tree_decoder import htd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // node_is_leaf, leaf_symbol[8:1], code_bit, zero pad
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // symbol[7:0], status[9:8], tree_complete, zero pad
	output logic [0:0]  m_axis_tuser   // symbol_valid
);

	op_t              op;
	logic             acc;
	logic             clr;
	logic             ld_en;
	logic             dec_en;
	logic             out_free;

	node_wr_t         node_wr;
	right_wr_t        right_wr;
	rd_req_t          link_rd;
	rd_req_t          walk_rd;
	bld_stat_t        bstat;
	logic             rd_leaf;
	logic [PAY_W-1:0] rd_pay;
	idx_t             rd_right;
	logic             root_hit;
	logic [SYM_W-1:0] root_sym;
	status_t          status;

	logic             vld_s1;
	logic             walk_s1;
	logic             val_s1;
	logic [SYM_W-1:0] sym_s1;
	status_t          status_s1;
	logic             tc_s1;

	logic             res_val;
	logic [SYM_W-1:0] res_sym;

	logic             out_vld_q;
	logic             out_val_q;
	logic [SYM_W-1:0] out_sym_q;
	status_t          out_status_q;
	logic             out_tc_q;

	// handshake
	assign out_free      = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !vld_s1 || out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser);

	// opcode decode
	always_comb begin
		clr    = 1'b0;
		ld_en  = 1'b0;
		dec_en = 1'b0;
		unique case (op)
			OP_CLEAR:  clr    = acc;
			OP_LOAD:   ld_en  = acc;
			OP_DECODE: dec_en = acc;
			OP_NONE:   ;
			default:   ;
		endcase
	end

	htd_builder u_builder (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.ld_en    (ld_en),
		.is_leaf  (s_axis_tdata[0]),
		.sym      (s_axis_tdata[8:1]),
		.link_pay (rd_pay),
		.node_wr  (node_wr),
		.right_wr (right_wr),
		.link_rd  (link_rd),
		.stat     (bstat)
	);

	htd_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.dec_en   (dec_en),
		.code_bit (s_axis_tdata[9]),
		.done     (bstat.done),
		.node_wr  (node_wr),
		.right_wr (right_wr),
		.rd_leaf  (rd_leaf),
		.rd_right (rd_right),
		.walk_rd  (walk_rd),
		.root_hit (root_hit),
		.root_sym (root_sym)
	);

	htd_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.node_wr  (node_wr),
		.right_wr (right_wr),
		.walk_rd  (walk_rd),
		.link_rd  (link_rd),
		.rd_leaf  (rd_leaf),
		.rd_pay   (rd_pay),
		.rd_right (rd_right)
	);

	// status of the beat being taken
	always_comb begin
		if (dec_en && !bstat.done) begin
			status = ST_EARLY;
		end else begin
			status = bstat.status;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			walk_s1   <= walk_rd.en;
			val_s1    <= root_hit;
			sym_s1    <= root_hit ? root_sym : '0;
			status_s1 <= status;
			tc_s1     <= bstat.done_nxt;
		end
	end

	// result from the table read of a walk beat
	assign res_val = walk_s1 ? rd_leaf : val_s1;
	assign res_sym = walk_s1 ? (rd_leaf ? rd_pay[SYM_W-1:0] : '0) : sym_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s1) begin
			out_val_q    <= res_val;
			out_sym_q    <= res_sym;
			out_status_q <= status_s1;
			out_tc_q     <= tc_s1;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_tc_q, out_status_q, out_sym_q};
	assign m_axis_tuser  = out_val_q;

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_axis_tready)
		else $error("input stalled with an empty read stage");

	a_sym_tree: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_val_q |-> out_tc_q && out_status_q == ST_OK)
		else $error("symbol emitted without a complete tree");

endmodule
